[hdl/alarm_match_table_macros.svh]
// ----------------------------------------------------------------------------
// alarm match table assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef ALARM_MATCH_TABLE_MACROS_SVH
`define ALARM_MATCH_TABLE_MACROS_SVH

// property that must hold at every clock edge
`define AMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent that must hold in the cycle after the trigger
`define AMT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (trig) |=> (cons)) else $error(msg);

`endif

[hdl/amt_pkg.sv]
// ----------------------------------------------------------------------------
// amt_pkg
// types and codes shared by the alarm match table and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

  // count width that covers the largest table (16 entries)
  localparam int unsigned CNT_W = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_NUM = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       armed;
  } entry_t;

  // broadcast to every cell for the current transfer
  typedef struct packed {
    logic             add_ok;
    logic             rm_ok;
    logic             chk;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] rm_pos;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/amt_cell.sv]
// ----------------------------------------------------------------------------
// amt_cell
// one table slot: holds an alarm time and armed flag, loads, shifts, fires
// ----------------------------------------------------------------------------
`default_nettype none

module amt_cell
  import amt_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     nb_i,
  output entry_t          entry_o,
  output logic            armed_d_o,
  output logic            fired_o
);

  localparam logic [CNT_W-1:0] IdxC  = CNT_W'(Idx);
  localparam logic [CNT_W-1:0] IdxN  = CNT_W'(Idx + 1);

  logic [4:0] hour_q;
  logic [5:0] minute_q, second_q;
  logic       armed_q;
  entry_t     cur, entry_d;
  logic       at_tail, shift, vacate, below, match;

  assign cur.hour   = hour_q;
  assign cur.minute = minute_q;
  assign cur.second = second_q;
  assign cur.armed  = armed_q;

  always_comb begin
    at_tail = ctrl_i.add_ok && (ctrl_i.count == IdxC);
    shift   = ctrl_i.rm_ok && (IdxC >= ctrl_i.rm_pos) && (IdxN < ctrl_i.count);
    vacate  = ctrl_i.rm_ok && (IdxN == ctrl_i.count);
    below   = IdxC < ctrl_i.count;
    match   = cur.armed && below && (cur.hour == ctrl_i.hour) &&
              (cur.minute == ctrl_i.minute) && (cur.second == ctrl_i.second);
    fired_o = ctrl_i.chk && match;

    entry_d = cur;
    if (at_tail) begin
      entry_d.hour   = ctrl_i.hour;
      entry_d.minute = ctrl_i.minute;
      entry_d.second = ctrl_i.second;
      entry_d.armed  = 1'b1;
    end else if (shift) begin
      entry_d = nb_i;
    end else if (vacate || fired_o) begin
      entry_d.armed = 1'b0;
    end
  end

  // time fields need no reset, only the armed flag
  always_ff @(posedge clk_i) begin
    hour_q   <= entry_d.hour;
    minute_q <= entry_d.minute;
    second_q <= entry_d.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else begin
      armed_q <= entry_d.armed;
    end
  end

  assign entry_o   = cur;
  assign armed_d_o = entry_d.armed;

endmodule

`default_nettype wire

[hdl/alarm_match_table.sv]
// ----------------------------------------------------------------------------
// alarm_match_table
// table of alarm times with add, remove by number and time check
//
// usage: an input transfer carries an operation (add, remove, check) with a
// time and a 1-based entry number; each input transfer yields exactly one
// output transfer with status, fired mask, entry count and armed mask as they
// stand after the operation.
// the result is registered and shows up in the cycle after the input
// transfer. one item per cycle is taken while the receiver keeps ready
// high; the whole table is updated in the same cycle by a row of cells, each
// comparing its own slot and taking its upper neighbor's slot on a remove.
// input ready is high whenever the output register is empty or is being
// taken, so a stalled receiver holds one result and blocks further input.
// reset clears the count, every armed flag and the output valid; stored
// times are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_match_table
  import amt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 5
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [4:0] time_hour_i,
  input  wire logic [5:0] time_minute_i,
  input  wire logic [5:0] time_second_i,
  input  wire logic [3:0] remove_number_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [4:0]      fired_mask_o,
  output logic [2:0]      entry_count_o,
  output logic [4:0]      armed_mask_o
);

`include "alarm_match_table_macros.svh"

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FullC = CNT_W'(TABLE_ENTRIES);

  // count and handshake
  logic [CW-1:0]    count_q, count_d;
  logic [CNT_W-1:0] count_ext;
  logic             accept;
  logic             add_ok, rm_ok, is_add, is_rm, is_chk;
  logic [CNT_W-1:0] num_ext;
  status_e          status_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q;
  logic [4:0]       fired_q, fired_d;
  logic [2:0]       count_out_q;
  logic [4:0]       armed_out_q, armed_out_d;

  // cell row
  cell_ctrl_t                 ctrl;
  entry_t [TABLE_ENTRIES-1:0] entries;
  logic   [TABLE_ENTRIES-1:0] armed_nx;
  logic   [TABLE_ENTRIES-1:0] fired_vec;
  logic   [TABLE_ENTRIES-1:0] armed_now;
  logic   [TABLE_ENTRIES-1:0] above_mask;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_ext  = CNT_W'(count_q);
  assign num_ext    = CNT_W'(remove_number_i);

  // decode the operation
  always_comb begin
    is_add = 1'b0;
    is_rm  = 1'b0;
    is_chk = 1'b0;
    case (op_e'(operation_i))
      OP_ADD:    is_add = accept;
      OP_REMOVE: is_rm  = accept;
      OP_CHECK:  is_chk = accept;
      default:   ;
    endcase
  end

  always_comb begin
    add_ok   = is_add && (count_ext < FullC);
    rm_ok    = is_rm && (remove_number_i != 4'd0) && (num_ext <= count_ext);
    status_d = ST_OK;
    if (is_add && !add_ok) begin
      status_d = ST_FULL;
    end else if (is_rm && !rm_ok) begin
      status_d = ST_BAD_NUM;
    end
    count_d = count_q;
    if (add_ok) begin
      count_d = count_q + CW'(1);
    end else if (rm_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  // control broadcast to every cell
  always_comb begin
    ctrl.add_ok = add_ok;
    ctrl.rm_ok  = rm_ok;
    ctrl.chk    = is_chk;
    ctrl.count  = count_ext;
    ctrl.rm_pos = num_ext - CNT_W'(1);
    ctrl.hour   = time_hour_i;
    ctrl.minute = time_minute_i;
    ctrl.second = time_second_i;
  end

  // row of cells, each one taking its upper neighbor's slot on a remove
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t nb;
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = entries[i+1];
    end

    amt_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .nb_i      (nb),
      .entry_o   (entries[i]),
      .armed_d_o (armed_nx[i]),
      .fired_o   (fired_vec[i])
    );

    assign armed_now[i]  = entries[i].armed;
    assign above_mask[i] = CNT_W'(i) >= count_ext;
  end

  // fit the masks to the five-bit outputs, truncating or zero filling
  for (genvar b = 0; b < 5; b++) begin : g_mask
    if (b < TABLE_ENTRIES) begin : g_on
      assign fired_d[b]     = fired_vec[b];
      assign armed_out_d[b] = armed_nx[b];
    end else begin : g_off
      assign fired_d[b]     = 1'b0;
      assign armed_out_d[b] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      fired_q     <= fired_d;
      count_out_q <= 3'(CNT_W'(count_d));
      armed_out_q <= armed_out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign fired_mask_o  = fired_q;
  assign entry_count_o = count_out_q;
  assign armed_mask_o  = armed_out_q;

  // the count never passes the table size
  `AMT_ASSERT(a_count_bound, count_ext <= FullC, "entry count beyond table size")

  // no slot at or above the count is armed
  `AMT_ASSERT(a_armed_below, (armed_now & above_mask) == '0, "armed slot above count")

  // add into a full table reports full and keeps the count
  `AMT_ASSERT_NEXT(a_full_add, is_add && (count_ext == FullC),
    (status_o == ST_FULL) && $stable(count_q), "full add not rejected")

  // only a check may fire alarms
  `AMT_ASSERT_NEXT(a_fire_on_check, accept && !is_chk, fired_mask_o == 5'd0,
    "alarm fired outside check")

endmodule

`default_nettype wire
